// ===== hdl/vrbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbr_pkg
// Shared types, constants and the arctangent table for the vertex rotator.
// ----------------------------------------------------------------------------
package vrbr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_ITERS   = 24;
    localparam int SQRT_STEPS     = 25;
    localparam int NUM_CELLS      = 25;   // max of the two step counts
    localparam int XW             = 52;   // CORDIC datapath width
    localparam int SVW            = 50;   // squared distance width
    localparam int REMW           = 28;   // square root remainder width
    localparam int RADW           = 25;   // radius width

    typedef enum logic [1:0] {
        REG_CENTER_X   = 2'd0,
        REG_CENTER_Y   = 2'd1,
        REG_TURN_ANGLE = 2'd2
    } t_reg_idx;

    // one beat moving down the cell chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
        logic                 fin;
        logic [SVW-1:0]       sv;
        logic [REMW-1:0]      rem;
        logic [RADW-1:0]      root;
    } t_tok;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2E;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/vrbr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbr_cell
// One chain cell: a CORDIC rotation step and a square root digit step.
// ----------------------------------------------------------------------------
module vrbr_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  vrbr_pkg::t_tok  i_tok,
    output logic            o_vld,
    output vrbr_pkg::t_tok  o_tok
);

    logic                          r_vld;
    vrbr_pkg::t_tok                r_tok;
    vrbr_pkg::t_tok                n_tok;
    logic signed [vrbr_pkg::XW-1:0] x_in;
    logic signed [vrbr_pkg::XW-1:0] y_in;
    logic signed [vrbr_pkg::XW-1:0] xs;
    logic signed [vrbr_pkg::XW-1:0] ys;
    logic [vrbr_pkg::REMW-1:0]      rem_sh;
    logic [vrbr_pkg::REMW-1:0]      trial;

    always_comb begin
        x_in   = i_tok.x;
        y_in   = i_tok.y;
        xs     = x_in >>> IDX;
        ys     = y_in >>> IDX;
        n_tok  = i_tok;
        if (IDX < vrbr_pkg::CORDIC_ITERS) begin
            if (!i_tok.z[31]) begin
                n_tok.x = x_in - ys;
                n_tok.y = y_in + xs;
                n_tok.z = i_tok.z - vrbr_pkg::atan_turn(IDX);
            end else begin
                n_tok.x = x_in + ys;
                n_tok.y = y_in - xs;
                n_tok.z = i_tok.z + vrbr_pkg::atan_turn(IDX);
            end
        end
        // restoring square root, two radicand bits per cell
        rem_sh = {i_tok.rem[vrbr_pkg::REMW-3:0], i_tok.sv[vrbr_pkg::SVW-1 -: 2]};
        trial  = {1'b0, i_tok.root, 2'b01};
        n_tok.sv = {i_tok.sv[vrbr_pkg::SVW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_tok.rem  = rem_sh - trial;
            n_tok.root = {i_tok.root[vrbr_pkg::RADW-2:0], 1'b1};
        end else begin
            n_tok.rem  = rem_sh;
            n_tok.root = {i_tok.root[vrbr_pkg::RADW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

// ===== hdl/vrbr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbr_front
// Offset, quadrant fold, gain and squares, running maximum; feeds the chain.
// ----------------------------------------------------------------------------
module vrbr_front #(
    parameter int ANGLE_BITS = vrbr_pkg::ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [23:0] i_vx,
    input  logic signed [23:0] i_vy,
    input  logic               i_fin,
    input  logic signed [23:0] i_cx,
    input  logic signed [23:0] i_cy,
    input  logic [15:0]        i_angle,
    output logic               o_vld,
    output vrbr_pkg::t_tok     o_tok
);

    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic signed [24:0] KGAIN = 25'sd10188014;

    logic [31:0]        z_raw;
    logic signed [24:0] dx;
    logic signed [24:0] dy;

    // stage 0
    logic               r0_vld;
    logic signed [24:0] r0_dx;
    logic signed [24:0] r0_dy;
    logic               r0_neg;
    logic [31:0]        r0_z;
    logic               r0_fin;
    // stage 1
    logic                           r1_vld;
    logic signed [vrbr_pkg::XW-1:0] r1_x;
    logic signed [vrbr_pkg::XW-1:0] r1_y;
    logic [vrbr_pkg::SVW-1:0]       r1_sqx;
    logic [vrbr_pkg::SVW-1:0]       r1_sqy;
    logic [31:0]                    r1_z;
    logic                           r1_fin;
    // stage 2
    logic                     r_vld;
    vrbr_pkg::t_tok           r_tok;
    logic [vrbr_pkg::SVW-1:0] r_max;

    logic signed [24:0]       fdx;
    logic signed [24:0]       fdy;
    logic signed [49:0]       px;
    logic signed [49:0]       py;
    logic signed [49:0]       sqx;
    logic signed [49:0]       sqy;
    logic [vrbr_pkg::SVW-1:0] d2;
    logic [vrbr_pkg::SVW-1:0] nmax;

    always_comb begin
        z_raw = 32'(({16'b0, i_angle} & AMASK) << (32 - ANGLE_BITS));
        dx    = 25'(i_vx) - 25'(i_cx);
        dy    = 25'(i_vy) - 25'(i_cy);
        fdx   = r0_neg ? -r0_dx : r0_dx;
        fdy   = r0_neg ? -r0_dy : r0_dy;
        px    = 50'(fdx) * 50'(KGAIN);
        py    = 50'(fdy) * 50'(KGAIN);
        sqx   = 50'(r0_dx) * 50'(r0_dx);
        sqy   = 50'(r0_dy) * 50'(r0_dy);
        d2    = r1_sqx + r1_sqy;
        nmax  = (d2 > r_max) ? d2 : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r_vld  <= 1'b0;
            r_max  <= '0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r_vld  <= r1_vld;
            if (r1_vld) begin
                r_max <= r1_fin ? '0 : nmax;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_dx  <= dx;
            r0_dy  <= dy;
            r0_neg <= (z_raw > 32'h40000000) && (z_raw < 32'hC0000000);
            r0_z   <= {z_raw[31] ^ ((z_raw > 32'h40000000) && (z_raw < 32'hC0000000)),
                       z_raw[30:0]};
            r0_fin <= i_fin;
            r1_x   <= vrbr_pkg::XW'(px);
            r1_y   <= vrbr_pkg::XW'(py);
            r1_sqx <= vrbr_pkg::SVW'(sqx);
            r1_sqy <= vrbr_pkg::SVW'(sqy);
            r1_z   <= r0_z;
            r1_fin <= r0_fin;
            r_tok.x    <= r1_x;
            r_tok.y    <= r1_y;
            r_tok.z    <= r1_z;
            r_tok.fin  <= r1_fin;
            r_tok.sv   <= r1_fin ? nmax : '0;
            r_tok.rem  <= '0;
            r_tok.root <= '0;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

// ===== hdl/vertex_rotate_bound_radius.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_bound_radius
// Rotates vertices about a centre and reports the shape's bounding radius.
// ----------------------------------------------------------------------------
// A fully pipelined block: it takes one vertex beat per clock while the output
// is not stalled, passes each through 3 front stages, 25 chain cells and 1
// output register, and returns the rotated vertices in order. Each of the 25
// cells does one CORDIC step (24 in use) and one square root digit (25 digits
// for the 25-bit radius). A stall on the output holds the whole pipe.
// Configuration is taken at any time but must be written while the pipe is empty.
// ----------------------------------------------------------------------------
module vertex_rotate_bound_radius #(
    parameter int ANGLE_BITS = vrbr_pkg::ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // vertex in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vert_x [23:0], vert_y [47:24]
    input  logic        s_axis_tlast,   // final_vertex
    // rotated vertex out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // rot_x [23:0], rot_y [47:24],
                                        // bound_radius [72:48], zero pad
    output logic        m_axis_tlast,   // final_out
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // config registers
    logic signed [23:0] r_cx;
    logic signed [23:0] r_cy;
    logic [15:0]        r_angle;

    // global advance: the output register is free or being drained
    logic en;

    logic           vld [vrbr_pkg::NUM_CELLS+1];
    vrbr_pkg::t_tok tok [vrbr_pkg::NUM_CELLS+1];

    logic               r_out_valid;
    logic [79:0]        r_out_data;
    logic               r_out_last;

    logic signed [vrbr_pkg::XW-1:0] xr;
    logic signed [vrbr_pkg::XW-1:0] yr;
    logic signed [28:0]             sx;
    logic signed [28:0]             sy;
    logic signed [23:0]             rx;
    logic signed [23:0]             ry;
    logic [vrbr_pkg::RADW-1:0]      rad;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_angle <= '0;
        end else if (i_cfg_valid) begin
            case (vrbr_pkg::t_reg_idx'(i_cfg_index))
                vrbr_pkg::REG_CENTER_X:   r_cx    <= i_cfg_data;
                vrbr_pkg::REG_CENTER_Y:   r_cy    <= i_cfg_data;
                vrbr_pkg::REG_TURN_ANGLE: r_angle <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    vrbr_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_vx    (s_axis_tdata[23:0]),
        .i_vy    (s_axis_tdata[47:24]),
        .i_fin   (s_axis_tlast),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_angle (r_angle),
        .o_vld   (vld[0]),
        .o_tok   (tok[0])
    );

    for (genvar g = 0; g < vrbr_pkg::NUM_CELLS; g++) begin : g_cell
        vrbr_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[g]),
            .i_tok   (tok[g]),
            .o_vld   (vld[g+1]),
            .o_tok   (tok[g+1])
        );
    end

    // round half up, back to Q15.8, re-add centre, saturate
    always_comb begin
        xr  = tok[vrbr_pkg::NUM_CELLS].x + vrbr_pkg::XW'(1 << 23);
        yr  = tok[vrbr_pkg::NUM_CELLS].y + vrbr_pkg::XW'(1 << 23);
        sx  = 29'(r_cx) + 29'($signed(xr[51:24]));
        sy  = 29'(r_cy) + 29'($signed(yr[51:24]));
        if (sx > 29'sd8388607)       rx = 24'sh7FFFFF;
        else if (sx < -29'sd8388608) rx = 24'sh800000;
        else                         rx = sx[23:0];
        if (sy > 29'sd8388607)       ry = 24'sh7FFFFF;
        else if (sy < -29'sd8388608) ry = 24'sh800000;
        else                         ry = sy[23:0];
        rad = tok[vrbr_pkg::NUM_CELLS].root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vld[vrbr_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {7'b0, rad, ry, rx};
            r_out_last <= tok[vrbr_pkg::NUM_CELLS].fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // CORDIC residual angle has converged by the chain end
    a_angle_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[vrbr_pkg::NUM_CELLS] |->
            (tok[vrbr_pkg::NUM_CELLS].z < 32'h00000400) ||
            (tok[vrbr_pkg::NUM_CELLS].z > 32'hFFFFFC00))
        else $error("CORDIC residual angle did not converge");

    // square root remainder bounded by twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[vrbr_pkg::NUM_CELLS] |->
            (tok[vrbr_pkg::NUM_CELLS].rem <= {2'b00, tok[vrbr_pkg::NUM_CELLS].root, 1'b0}))
        else $error("square root remainder out of range");

    // radius only on the last vertex of a shape
    a_rad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[72:48] == '0))
        else $error("radius reported on a non-final vertex");
`endif

endmodule

// ===== sim/tb_vertex_rotate_bound_radius.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_rotate_bound_radius
// Self-checking bench for the vertex rotator and bounding radius block.
// ----------------------------------------------------------------------------
// Vertex beats go in on the slave stream. A bit-true CORDIC and integer square
// root predictor in the scoreboard computes each rotated point and radius, and
// the master-side beats are checked in order against it. The run steps through
// several centre and angle settings, written only while the pipe is empty, and
// through idle phases on both sides.
// ----------------------------------------------------------------------------
module tb_vertex_rotate_bound_radius;

    // one expected output beat
    typedef struct {
        logic [23:0] rx;
        logic [23:0] ry;
        logic [24:0] rad;
        logic        fin;
    } t_rot_beat;

    class rot_scoreboard;
        longint ctr_x, ctr_y;
        logic [15:0] angle;
        logic [49:0] peak_dsq;
        t_rot_beat pending[$];
        int errors;

        function new();
            ctr_x = 0; ctr_y = 0; angle = 0; peak_dsq = 0; errors = 0;
        endfunction

        function void set_reg(vrbr_pkg::t_reg_idx idx, logic [23:0] val);
            case (idx)
                vrbr_pkg::REG_CENTER_X:   ctr_x = longint'($signed(val));
                vrbr_pkg::REG_CENTER_Y:   ctr_y = longint'($signed(val));
                vrbr_pkg::REG_TURN_ANGLE: angle = val[15:0];
                default: ;
            endcase
        endfunction

        static function longint clamp24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        static function longint floor_root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // vertex accepted: work out its output beat
        function void note_vertex(logic [23:0] vx, logic [23:0] vy, logic fin);
            longint dx, dy, x, y, xs, ys, ox, oy;
            logic [31:0] z;
            longint unsigned d2;
            t_rot_beat b;
            dx = longint'($signed(vx)) - ctr_x;
            dy = longint'($signed(vy)) - ctr_y;
            d2 = dx * dx + dy * dy;
            z = {angle, 16'd0};
            if (z > 32'h40000000 && z < 32'hC0000000) begin
                dx = -dx; dy = -dy;
                z = z - 32'h80000000;
            end
            x = dx * 10188014;
            y = dy * 10188014;
            for (int i = 0; i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (!z[31]) begin
                    x = x - ys; y = y + xs; z = z - vrbr_pkg::atan_turn(i);
                end else begin
                    x = x + ys; y = y - xs; z = z + vrbr_pkg::atan_turn(i);
                end
            end
            ox = (x + (64'sd1 <<< 23)) >>> 24;
            oy = (y + (64'sd1 <<< 23)) >>> 24;
            b.rx = 24'(clamp24(ctr_x + ox));
            b.ry = 24'(clamp24(ctr_y + oy));
            if (d2 > peak_dsq) peak_dsq = 50'(d2);
            b.rad = '0;
            if (fin) begin
                b.rad = 25'(floor_root(peak_dsq));
                peak_dsq = 0;
            end
            b.fin = fin;
            pending.insert(pending.size(), b);
        endfunction

        function void check_beat(logic [79:0] data, logic last);
            t_rot_beat e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h last %b", data, last);
                return;
            end
            e = pending.pop_front();
            if (data[23:0] !== e.rx || data[47:24] !== e.ry || data[72:48] !== e.rad
                || data[79:73] !== 7'd0 || last !== e.fin) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp x %h y %h r %h l %b, got x %h y %h r %h l %b",
                             e.rx, e.ry, e.rad, e.fin,
                             data[23:0], data[47:24], data[72:48], last);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    rot_scoreboard sb = new();
    int  send_idle_pct = 0;     // sender gap odds, percent
    int  recv_stall_pct = 0;    // receiver stall odds, percent
    int  cycles = 0;

    vertex_rotate_bound_radius DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(vrbr_pkg::t_reg_idx idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_vertex(logic [23:0] vx, logic [23:0] vy, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vy, vx};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_vertex(vx, vy, fin);
    endtask

    // pipe empty: all beats back plus margin
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random field, biased towards extremes and small values
    function automatic logic [23:0] rand_coord();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($signed($urandom_range(8000)) - 4000);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic run_shapes(int n_items);
        int left, len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 1);
            if (len > left) len = left;
            for (int k = 0; k < len; k++)
                send_vertex(rand_coord(), rand_coord(), k == len - 1);
            left -= len;
        end
    endtask

    initial begin
        logic [23:0] ext[4];
        ext = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, vertex at the centre, single-vertex shape
        foreach (ext[a]) send_vertex(ext[a], ext[3 - a], 1'b0);
        send_vertex(24'h000000, 24'h000000, 1'b1);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 1'b1);
        drain();
        write_reg(vrbr_pkg::REG_CENTER_X, 24'h800000);
        write_reg(vrbr_pkg::REG_CENTER_Y, 24'h7FFFFF);
        write_reg(vrbr_pkg::REG_TURN_ANGLE, 24'h004000);
        send_vertex(24'h800000, 24'h7FFFFF, 1'b0);    // at the centre
        send_vertex(24'h7FFFFF, 24'h800000, 1'b1);    // farthest corner
        drain();
        foreach (ext[a]) begin
            write_reg(vrbr_pkg::REG_TURN_ANGLE, {8'd0, ext[a][15:0]});
            send_vertex(24'h012345, 24'hFEDCBA, 1'b0);
            send_vertex(ext[a], ext[(a + 1) % 4], a[0]);
            drain();
        end
        write_reg(vrbr_pkg::REG_TURN_ANGLE, 24'h008000);
        send_vertex(24'h000100, 24'h000200, 1'b1);
        drain();

        // random: phases of idling, settings changed between them
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_reg(vrbr_pkg::REG_CENTER_X, (ph % 3 == 0) ? 24'h000000 : rand_coord());
            write_reg(vrbr_pkg::REG_CENTER_Y, (ph % 3 == 0) ? 24'h000000 : rand_coord());
            write_reg(vrbr_pkg::REG_TURN_ANGLE, {8'd0, 16'($urandom())});
            run_shapes(150);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
